// ===== design/wmfe_pkg.sv =====
// ----------------------------------------------------------------------------
// wmfe_pkg - websocket masked frame encoder definitions
// command codes, frame constants and mask helper functions
// ----------------------------------------------------------------------------
package wmfe_pkg;

    typedef logic [7:0] t_byte;

    // command codes carried on the slave-side tuser
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_PAYLOAD = 2'd1;
    localparam logic [1:0] CMD_CLOSE   = 2'd2;

    localparam int          LEN_W     = 63;
    localparam int          BUF_DEPTH = 14;
    localparam int          CNT_W     = $clog2(BUF_DEPTH + 1);

    localparam logic [31:0] SEED_RESET = 32'hDEADBEEF;
    localparam t_byte       OP_TEXT    = 8'h81;
    localparam t_byte       OP_CLOSE   = 8'h88;
    localparam t_byte       MASK_BIT   = 8'h80;
    localparam t_byte       LEN16_CODE = 8'd126;
    localparam t_byte       LEN64_CODE = 8'd127;
    localparam t_byte       STATUS_HI  = 8'h03;
    localparam t_byte       STATUS_LO  = 8'hE8;
    localparam logic [LEN_W-1:0] LEN16_MIN = LEN_W'(126);
    localparam logic [LEN_W-1:0] LEN64_MIN = LEN_W'(65536);

    // xorshift32 with shifts 13, 17, 5
    function automatic logic [31:0] xorshift32(input logic [31:0] x_in);
        logic [31:0] x;
        x = x_in;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    // mask byte by position, most significant first
    function automatic t_byte mask_byte(input logic [31:0] m, input logic [1:0] idx);
        t_byte b;
        case (idx)
            2'd0:    b = m[31:24];
            2'd1:    b = m[23:16];
            2'd2:    b = m[15:8];
            default: b = m[7:0];
        endcase
        return b;
    endfunction

endpackage

// ===== design/websocket_masked_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// websocket_masked_frame_encoder - client-side websocket frame builder
// builds masked text and close frames as a byte stream
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata / tuser                               handshake
//  -------  ---  ------------------------------------------  ----------------
//  s        in   tdata: frame_length, data_byte; tuser: cmd   tvalid / tready
//  m        out  tdata: out_byte; tlast: frame_last           tvalid / tready
//  cfg      in   wdata: mask_seed                             we, no wait
//
//  payload bytes stream one per cycle while the output is not stalled
//  a start command occupies the input while 6, 8 or 14 header bytes drain,
//  a close command while 8 drain: the burst buffer drains one byte a cycle unless stalled
//  output is registered; the next input is taken as the last buffered byte
//  moves to the output register, so a stalled output only backs up the buffer
//  reset (synchronous, active low) loads the seed 0xdeadbeef and clears state
//
module websocket_masked_frame_encoder
    import wmfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,     // mask_seed
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,       // [62:0] frame_length, [70:63] data_byte, [71] zero
    input  logic [1:0]  i_s_tuser,       // [1:0] cmd
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,       // [7:0] out_byte
    output logic        o_m_tlast        // frame_last
);

    // encoder state
    logic [31:0]      r_gen,  n_gen;
    logic [31:0]      r_mask, n_mask;
    logic [1:0]       r_pos,  n_pos;
    logic [LEN_W-1:0] r_rem,  n_rem;
    logic             r_open, n_open;

    // burst buffer, head at entry 0
    t_byte            r_buf [BUF_DEPTH];
    t_byte            n_buf [BUF_DEPTH];
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             r_blast, n_blast;   // final buffered byte closes a frame

    // output register
    logic             r_ovalid;
    t_byte            r_odata;
    logic             r_olast;

    logic             s_accept;
    logic             out_move;
    logic [LEN_W-1:0] in_len;
    t_byte            in_data;
    logic [31:0]      draw;
    logic [63:0]      len64;
    logic [LEN_W-1:0] rem_dec;

    assign in_len  = i_s_tdata[LEN_W-1:0];
    assign in_data = i_s_tdata[LEN_W+7:LEN_W];
    assign len64   = {1'b0, in_len};
    assign draw    = xorshift32(r_gen);
    assign rem_dec = r_rem - LEN_W'(1);

    // head byte moves into the output register when that register is free
    assign out_move   = (r_cnt != '0) && (!r_ovalid || i_m_tready);
    // accept once the buffer will be empty by the next edge
    assign o_s_tready = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && out_move);
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_gen   = r_gen;
        n_mask  = r_mask;
        n_pos   = r_pos;
        n_rem   = r_rem;
        n_open  = r_open;
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_blast = r_blast;

        // drain one byte
        if (out_move) begin
            for (int i = 0; i < BUF_DEPTH - 1; i++) begin
                n_buf[i] = r_buf[i+1];
            end
            n_cnt = r_cnt - CNT_W'(1);
        end

        if (s_accept) begin
            case (i_s_tuser)
                CMD_START: begin
                    n_gen    = draw;
                    n_mask   = draw;
                    n_pos    = 2'd0;
                    n_rem    = in_len;
                    n_open   = (in_len != '0);
                    n_blast  = (in_len == '0);
                    n_buf[0] = OP_TEXT;
                    if (in_len < LEN16_MIN) begin
                        // short form: length in the second byte
                        n_buf[1] = MASK_BIT | {1'b0, in_len[6:0]};
                        for (int i = 0; i < 4; i++) begin
                            n_buf[2+i] = mask_byte(draw, 2'(i));
                        end
                        n_cnt = CNT_W'(6);
                    end else if (in_len < LEN64_MIN) begin
                        // 16-bit extended length
                        n_buf[1] = MASK_BIT | LEN16_CODE;
                        n_buf[2] = in_len[15:8];
                        n_buf[3] = in_len[7:0];
                        for (int i = 0; i < 4; i++) begin
                            n_buf[4+i] = mask_byte(draw, 2'(i));
                        end
                        n_cnt = CNT_W'(8);
                    end else begin
                        // 64-bit extended length, big-endian
                        n_buf[1] = MASK_BIT | LEN64_CODE;
                        for (int i = 0; i < 8; i++) begin
                            n_buf[2+i] = len64[56-8*i +: 8];
                        end
                        for (int i = 0; i < 4; i++) begin
                            n_buf[10+i] = mask_byte(draw, 2'(i));
                        end
                        n_cnt = CNT_W'(BUF_DEPTH);
                    end
                end
                CMD_PAYLOAD: begin
                    // dropped when no frame is open
                    if (r_open) begin
                        n_rem    = rem_dec;
                        n_buf[0] = in_data ^ mask_byte(r_mask, r_pos);
                        n_blast  = (rem_dec == '0);
                        n_pos    = r_pos + 2'd1;
                        n_open   = (rem_dec != '0);
                        n_cnt    = CNT_W'(1);
                    end else begin
                        n_cnt    = '0;
                    end
                end
                CMD_CLOSE: begin
                    // masked close frame, status 1000
                    n_gen    = draw;
                    n_mask   = draw;
                    n_open   = 1'b0;
                    n_rem    = '0;
                    n_pos    = 2'd0;
                    n_blast  = 1'b1;
                    n_buf[0] = OP_CLOSE;
                    n_buf[1] = MASK_BIT | 8'd2;
                    for (int i = 0; i < 4; i++) begin
                        n_buf[2+i] = mask_byte(draw, 2'(i));
                    end
                    n_buf[6] = STATUS_HI ^ mask_byte(draw, 2'd0);
                    n_buf[7] = STATUS_LO ^ mask_byte(draw, 2'd1);
                    n_cnt    = CNT_W'(8);
                end
                default: begin
                    // unused command: no result, no state change
                    n_cnt = '0;
                end
            endcase
        end

        // seed write reloads the generator; zero would lock it
        if (i_cfg_we) begin
            n_gen = (i_cfg_wdata == 32'd0) ? SEED_RESET : i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen    <= SEED_RESET;
            r_mask   <= '0;
            r_pos    <= '0;
            r_rem    <= '0;
            r_open   <= 1'b0;
            r_cnt    <= '0;
            r_blast  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_gen   <= n_gen;
            r_mask  <= n_mask;
            r_pos   <= n_pos;
            r_rem   <= n_rem;
            r_open  <= n_open;
            r_cnt   <= n_cnt;
            r_blast <= n_blast;
            if (out_move) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (out_move) begin
            r_odata <= r_buf[0];
            r_olast <= r_blast && (r_cnt == CNT_W'(1));
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

endmodule
